// ===== rtl/are_pkg.sv =====
// Package with shared constants and types for the angular rate estimator.
package are_pkg;

    localparam int MaxPinsDefault   = 16;
    localparam int AngleBitsDefault = 16;

    localparam logic [31:0] MinIntervalReset = 32'd1000;
    localparam logic [14:0] MatchLimitReset  = 15'd5215;

    localparam logic [46:0] Sat47 = {47{1'b1}};

    typedef enum logic [1:0] {
        REG_ENABLE       = 2'd0,
        REG_MIN_INTERVAL = 2'd1,
        REG_MATCH_LIMIT  = 2'd2
    } reg_index_t;

endpackage

// ===== rtl/angular_rate_estimator.sv =====
// Top level of the angular rate estimator: pin matching, rate division and speed blending.
//
// Input words arrive on the s_axis channel: tdata holds the angle and frame time,
// tuser the has_pin flag and tlast marks the last word of a frame. One result word
// leaves on m_axis for each frame end while the tracker is enabled. Registers are
// written on the cfg channel while the block is idle; writing enable as one also
// clears the tracker.
// A pin word that is stored takes a read and a compare for each angle stored for the
// previous frame, then an accumulate step, before the next word is accepted. A frame
// end then passes a check; when it updates, the rate quotient and the acceleration
// quotient each come from a shared restoring divider that retires one quotient bit per
// cycle, the count-by-interval product uses a shift-and-add multiplier of one step per
// count bit plus one, and the blend by five folds and then corrects its quotient.
// The output register holds a result until it is taken; pin words are still accepted
// meanwhile, but a further frame end waits in its last step and configuration waits
// until the register is free.
// Reset clears the configuration to its defaults and empties the tracker; the
// angle store needs no clearing because only entries written in this run are read.
module angular_rate_estimator
    import are_pkg::*;
#(
    parameter int MAX_PINS   = MaxPinsDefault,
    parameter int ANGLE_BITS = AngleBitsDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // angle [15:0], frame_time [47:16]
    input  logic         s_axis_tuser,   // has_pin
    input  logic         s_axis_tlast,   // frame_end
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // speed [47:0], acceleration [94:48], pad
    output logic [6:0]   m_axis_tuser,   // updated [0], matched [5:1], truncated [6]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int PW = $clog2(MAX_PINS + 1);
    localparam int IW = (MAX_PINS > 1) ? $clog2(MAX_PINS) : 1;
    localparam int DEPTH = 2 * (1 << IW);
    localparam int AW = $clog2(DEPTH);
    localparam int SW = ANGLE_BITS + PW + 1;
    localparam int CW = PW + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_CMP, ST_ACC, ST_CHECK, ST_MUL, ST_DIV1, ST_BLEND,
        ST_DIV2, ST_FOLD, ST_FIX, ST_DONE, ST_OUT
    } state_t;

    state_t state_reg;

    logic        enable_reg;
    logic [31:0] min_interval_reg;
    logic [14:0] match_limit_reg;

    logic [ANGLE_BITS-1:0] bank_mem [DEPTH];
    logic [ANGLE_BITS-1:0] rd_reg;

    logic          bank_reg;
    logic [PW-1:0] prev_cnt_reg, cur_cnt_reg, match_cnt_reg, j_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [47:0] speed_reg;
    logic [46:0]   accel_reg;
    logic [31:0]   last_time_reg;
    logic          ovf_reg;

    logic [ANGLE_BITS-1:0] pin_reg;
    logic [31:0] now_reg;
    logic        end_reg;
    logic        found_reg;
    logic signed [ANGLE_BITS:0] best_reg;
    logic [31:0] dt_reg;

    logic [63:0] prod_reg;
    logic [CW-1:0] mcand_reg;
    logic [2:0]  mstep_reg;
    logic [63:0] num_reg;
    logic [64:0] rem_reg;
    logic [63:0] quo_reg;
    logic [6:0]  dstep_reg;
    logic        neg_reg;
    logic signed [48:0] r_reg;
    logic        updated_reg;
    logic [PW-1:0] matched_reg;
    logic [50:0] n5_reg;
    logic [50:0] q5_reg;
    logic        neg5_reg;

    logic signed [ANGLE_BITS:0] d_w;
    logic [ANGLE_BITS:0] abs_d, abs_best;
    logic [ANGLE_BITS-1:0] diff_raw;
    logic [SW-1:0] abs_sum;
    logic [64:0] rem_sh, rem_sub;
    logic signed [50:0] blend_num;
    logic signed [50:0] rs_diff;
    logic [50:0] r5_w;
    logic [31:0] dt_full;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [ANGLE_BITS-1:0] in_angle;
    logic        out_free;

    assign in_angle = ANGLE_BITS'(s_axis_tdata[15:0]);
    assign diff_raw = pin_reg - rd_reg;
    assign d_w = diff_raw[ANGLE_BITS-1] ?
        $signed({1'b1, diff_raw}) : $signed({1'b0, diff_raw});
    assign abs_d = d_w[ANGLE_BITS] ? (~d_w + 1'b1) : d_w;
    assign abs_best = best_reg[ANGLE_BITS] ? (~best_reg + 1'b1) : best_reg;
    assign abs_sum = sum_reg[SW-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign rem_sh = {rem_reg[63:0], num_reg[63]};
    assign rem_sub = rem_sh - {1'b0, prod_reg};
    assign dt_full = now_reg - last_time_reg;
    assign rs_diff = 51'(r_reg) - 51'(speed_reg);
    assign blend_num = (51'(speed_reg) <<< 2) + 51'(r_reg);
    assign r5_w = n5_reg - ((q5_reg << 2) + q5_reg);
    assign wr_addr = AW'({bank_reg, cur_cnt_reg[IW-1:0]});
    assign rd_addr = AW'({~bank_reg, j_reg[IW-1:0]});
    assign out_free = !m_axis_tvalid || m_axis_tready;

    assign cfg_ready = (state_reg == ST_IDLE) && !m_axis_tvalid;
    assign s_axis_tready = (state_reg == ST_IDLE) && !(cfg_valid && cfg_ready);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_axis_tvalid && s_axis_tready && enable_reg &&
            s_axis_tuser && cur_cnt_reg < PW'(MAX_PINS)) begin
            bank_mem[wr_addr] <= in_angle;
        end
        rd_reg <= bank_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            enable_reg <= 1'b0;
            min_interval_reg <= MinIntervalReset;
            match_limit_reg <= MatchLimitReset;
            bank_reg <= 1'b0;
            prev_cnt_reg <= '0;
            cur_cnt_reg <= '0;
            match_cnt_reg <= '0;
            sum_reg <= '0;
            speed_reg <= '0;
            accel_reg <= '0;
            last_time_reg <= '0;
            ovf_reg <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid && cfg_ready) begin
                        unique case (cfg_index)
                            REG_ENABLE: begin
                                enable_reg <= cfg_data[0];
                                if (cfg_data[0]) begin
                                    bank_reg <= 1'b0;
                                    prev_cnt_reg <= '0;
                                    cur_cnt_reg <= '0;
                                    match_cnt_reg <= '0;
                                    sum_reg <= '0;
                                    speed_reg <= '0;
                                    accel_reg <= '0;
                                    last_time_reg <= '0;
                                    ovf_reg <= 1'b0;
                                end
                            end
                            REG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                            REG_MATCH_LIMIT:  match_limit_reg <= cfg_data[14:0];
                            default: ;
                        endcase
                    end else if (s_axis_tvalid && s_axis_tready && enable_reg) begin
                        pin_reg <= in_angle;
                        now_reg <= s_axis_tdata[47:16];
                        end_reg <= s_axis_tlast;
                        found_reg <= 1'b0;
                        j_reg <= '0;
                        if (s_axis_tuser) begin
                            if (cur_cnt_reg < PW'(MAX_PINS)) begin
                                cur_cnt_reg <= cur_cnt_reg + 1'b1;
                                state_reg <= (prev_cnt_reg != '0) ? ST_READ : ST_ACC;
                            end else begin
                                ovf_reg <= 1'b1;
                                state_reg <= s_axis_tlast ? ST_CHECK : ST_IDLE;
                            end
                        end else begin
                            state_reg <= s_axis_tlast ? ST_CHECK : ST_IDLE;
                        end
                    end
                end
                ST_READ: state_reg <= ST_CMP;
                ST_CMP: begin
                    if (!found_reg || abs_d < abs_best) begin
                        best_reg <= d_w;
                        found_reg <= 1'b1;
                    end
                    j_reg <= j_reg + 1'b1;
                    state_reg <= (j_reg + 1'b1 == prev_cnt_reg) ? ST_ACC : ST_READ;
                end
                ST_ACC: begin
                    if (found_reg && 32'(abs_best) < 32'(match_limit_reg)) begin
                        sum_reg <= sum_reg + SW'(best_reg);
                        match_cnt_reg <= match_cnt_reg + 1'b1;
                    end
                    state_reg <= end_reg ? ST_CHECK : ST_IDLE;
                end
                ST_CHECK: begin
                    updated_reg <= 1'b0;
                    matched_reg <= '0;
                    dt_reg <= dt_full;
                    state_reg <= ST_DONE;
                    if (last_time_reg != '0 && prev_cnt_reg != '0 && cur_cnt_reg != '0 &&
                        now_reg > last_time_reg && dt_full > min_interval_reg) begin
                        matched_reg <= match_cnt_reg;
                        if (match_cnt_reg != '0) begin
                            prod_reg <= '0;
                            mcand_reg <= CW'(match_cnt_reg);
                            mstep_reg <= '0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    if (mcand_reg[0]) begin
                        prod_reg <= prod_reg + (64'(dt_reg) << mstep_reg);
                    end
                    mcand_reg <= mcand_reg >> 1;
                    mstep_reg <= mstep_reg + 1'b1;
                    if (mstep_reg == 3'(CW - 1)) begin
                        num_reg <= 64'(abs_sum) << 16;
                        neg_reg <= sum_reg[SW-1];
                        rem_reg <= '0;
                        dstep_reg <= '0;
                        state_reg <= ST_DIV1;
                    end
                end
                ST_DIV1, ST_DIV2: begin
                    num_reg <= num_reg << 1;
                    if (!rem_sub[64]) begin
                        rem_reg <= rem_sub;
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    dstep_reg <= dstep_reg + 1'b1;
                    if (dstep_reg == 7'd63) begin
                        state_reg <= (state_reg == ST_DIV1) ? ST_BLEND : ST_FOLD;
                    end
                end
                ST_BLEND: begin
                    if (quo_reg > 64'(Sat47)) begin
                        r_reg <= neg_reg ? -49'(Sat47) : 49'(Sat47);
                    end else begin
                        r_reg <= neg_reg ? -49'(quo_reg[46:0]) : 49'(quo_reg[46:0]);
                    end
                    updated_reg <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (speed_reg == '0 || (speed_reg < 0 && r_reg > 0) ||
                        (speed_reg > 0 && r_reg < 0)) begin
                        speed_reg <= 48'(r_reg);
                        dstep_reg <= '0;
                        state_reg <= ST_DONE;
                    end else begin
                        n5_reg <= blend_num[50] ? 51'(-blend_num) : 51'(blend_num);
                        neg5_reg <= blend_num[50];
                        mstep_reg <= '0;
                        num_reg <= rs_diff[50] ? 64'(-rs_diff) : 64'(rs_diff);
                        prod_reg <= 64'(dt_reg);
                        rem_reg <= '0;
                        dstep_reg <= '0;
                        state_reg <= ST_DIV2;
                    end
                end
                ST_FOLD: begin
                    case (mstep_reg)
                        3'd0: q5_reg <= (n5_reg >> 1) + (n5_reg >> 2);
                        3'd1: q5_reg <= q5_reg + (q5_reg >> 4);
                        3'd2: q5_reg <= q5_reg + (q5_reg >> 8);
                        3'd3: q5_reg <= q5_reg + (q5_reg >> 16);
                        3'd4: q5_reg <= q5_reg + (q5_reg >> 32);
                        default: begin
                            q5_reg <= q5_reg >> 2;
                            state_reg <= ST_FIX;
                        end
                    endcase
                    mstep_reg <= mstep_reg + 1'b1;
                end
                ST_FIX: begin
                    if (r5_w >= 51'd5) begin
                        q5_reg <= q5_reg + 1'b1;
                    end else begin
                        speed_reg <= neg5_reg ? -48'(q5_reg) : 48'(q5_reg);
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        if (updated_reg && dstep_reg == 7'd64) begin
                            accel_reg <= (quo_reg > 64'(Sat47)) ? Sat47 : quo_reg[46:0];
                        end
                        m_axis_tdata <= {1'b0, (updated_reg && dstep_reg == 7'd64) ?
                            ((quo_reg > 64'(Sat47)) ? Sat47 : quo_reg[46:0]) : accel_reg,
                            speed_reg};
                        m_axis_tuser <= {ovf_reg, 5'(matched_reg), updated_reg};
                        prev_cnt_reg <= cur_cnt_reg;
                        bank_reg <= ~bank_reg;
                        cur_cnt_reg <= '0;
                        sum_reg <= '0;
                        match_cnt_reg <= '0;
                        ovf_reg <= 1'b0;
                        last_time_reg <= now_reg;
                        dstep_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== dv/tb_angular_rate_estimator.sv =====
// Self-checking testbench for the angular rate estimator with random stimulus and stalls.
module tb_angular_rate_estimator
    import are_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PinCap = 16;
    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic [15:0] angle;
        logic        has_pin;
        logic        frame_end;
        logic [31:0] frame_time;
    } pin_word_t;

    typedef struct packed {
        logic [47:0] speed;
        logic [46:0] accel;
        logic        updated;
        logic [4:0]  matched;
        logic        truncated;
    } rate_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [6:0] m_axis_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    angular_rate_estimator uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predictor state.
    logic        trk_en;
    logic [31:0] trk_min_dt;
    logic [14:0] trk_limit;
    logic [15:0] banks [2*PinCap];
    logic        bank_sel;
    int          prev_cnt, cur_cnt, match_cnt;
    longint      diff_acc, speed_est, accel_est;
    logic [31:0] prev_time;
    logic        pins_dropped;

    pin_word_t   pending_words[$];
    rate_word_t  expected_rates[$];
    int          fail_count = 0;
    bit          hold_feed = 0;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint wrapped(logic [15:0] a, logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return d[15] ? longint'(d) - 65536 : longint'(d);
    endfunction

    function automatic void clear_tracker();
        bank_sel = 0; prev_cnt = 0; cur_cnt = 0; match_cnt = 0;
        diff_acc = 0; speed_est = 0; accel_est = 0; prev_time = 0; pins_dropped = 0;
    endfunction

    function automatic void apply_reg(reg_index_t idx, logic [31:0] val);
        case (idx)
            REG_ENABLE: begin
                trk_en = val[0];
                if (val[0]) clear_tracker();
            end
            REG_MIN_INTERVAL: trk_min_dt = val;
            REG_MATCH_LIMIT: trk_limit = val[14:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_rate(pin_word_t w);
        int base;
        bit found;
        longint best, d, r, s;
        logic [63:0] q, acc, dt, num;
        rate_word_t res;
        logic upd;
        int mt;
        if (!trk_en) return;
        if (w.has_pin) begin
            if (cur_cnt < PinCap) begin
                base = bank_sel ? 0 : PinCap;
                found = 0; best = 0;
                for (int j = 0; j < prev_cnt; j++) begin
                    d = wrapped(w.angle, banks[base+j]);
                    if (!found || mag(d) < mag(best)) begin
                        best = d; found = 1;
                    end
                end
                if (found && mag(best) < longint'(trk_limit)) begin
                    diff_acc += best; match_cnt++;
                end
                banks[(bank_sel ? PinCap : 0) + cur_cnt] = w.angle;
                cur_cnt++;
            end else pins_dropped = 1;
        end
        if (!w.frame_end) return;
        upd = 0; mt = 0;
        if (prev_time != 0 && prev_cnt > 0 && cur_cnt > 0 && w.frame_time > prev_time) begin
            dt = 64'(w.frame_time - prev_time);
            if (dt > 64'(trk_min_dt)) begin
                mt = match_cnt;
                if (match_cnt > 0) begin
                    num = 64'(mag(diff_acc)) << 16;
                    q = num / (64'(match_cnt) * dt);
                    if (q > 64'(Sat47)) q = 64'(Sat47);
                    r = diff_acc < 0 ? -longint'(q) : longint'(q);
                    s = speed_est;
                    if (s == 0 || (s < 0 && r > 0) || (s > 0 && r < 0)) speed_est = r;
                    else begin
                        acc = 64'(mag(r - s)) / dt;
                        if (acc > 64'(Sat47)) acc = 64'(Sat47);
                        accel_est = longint'(acc);
                        speed_est = (4 * s + r) / 5;
                    end
                    upd = 1;
                end
            end
        end
        res.speed = speed_est[47:0];
        res.accel = accel_est[46:0];
        res.updated = upd;
        res.matched = mt[4:0];
        res.truncated = pins_dropped;
        expected_rates.insert(expected_rates.size(), res);
        prev_cnt = cur_cnt; bank_sel = ~bank_sel; cur_cnt = 0;
        diff_acc = 0; match_cnt = 0; pins_dropped = 0; prev_time = w.frame_time;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // Driver.
    int send_gap = 0;
    bit src_calm = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) predict_rate(pending_words[0]);
            if (s_axis_tvalid && s_axis_tready) void'(pending_words.pop_front());
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0 && !src_calm) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() > ((s_axis_tvalid && s_axis_tready) ? 0 : 0)
                             && !hold_feed && pending_words.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {pending_words[0].frame_time, pending_words[0].angle};
                    s_axis_tuser <= pending_words[0].has_pin;
                    s_axis_tlast <= pending_words[0].frame_end;
                    send_gap <= gap_len();
                    if ($urandom_range(0, 199) == 0) src_calm <= ~src_calm;
                end else s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor.
    int recv_gap = 0;
    int idle_cycles = 0;
    rate_word_t got, want;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.speed = m_axis_tdata[47:0];
                got.accel = m_axis_tdata[94:48];
                got.updated = m_axis_tuser[0];
                got.matched = m_axis_tuser[5:1];
                got.truncated = m_axis_tuser[6];
                if (expected_rates.size() == 0) begin
                    $error("unexpected result word");
                    fail_count++;
                end else begin
                    want = expected_rates.pop_front();
                    if (got.speed !== want.speed) begin
                        $error("speed expected %h actual %h", want.speed, got.speed); fail_count++;
                    end
                    if (got.accel !== want.accel) begin
                        $error("acceleration expected %h actual %h", want.accel, got.accel);
                        fail_count++;
                    end
                    if (got.updated !== want.updated) begin
                        $error("updated expected %0d actual %0d", want.updated, got.updated);
                        fail_count++;
                    end
                    if (got.matched !== want.matched) begin
                        $error("matched expected %0d actual %0d", want.matched, got.matched);
                        fail_count++;
                    end
                    if (got.truncated !== want.truncated) begin
                        $error("truncated expected %0d actual %0d", want.truncated,
                               got.truncated);
                        fail_count++;
                    end
                end
            end
            if (recv_gap > 0 && !src_calm) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready) recv_gap <= gap_len();
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready) || (pending_words.size() == 0
                && expected_rates.size() == 0 && !cfg_valid))
                idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_rates.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic void add_word(logic [15:0] a, logic p, logic e, logic [31:0] t);
        pin_word_t w;
        w.angle = a; w.has_pin = p; w.frame_end = e; w.frame_time = t;
        pending_words.insert(pending_words.size(), w);
    endfunction

    // One frame of npins pins spaced by spread from start plus jitter, or one empty end word.
    function automatic void add_frame(int npins, logic [15:0] start, logic [15:0] spread,
                                      logic [31:0] t);
        for (int i = 0; i < npins; i++)
            add_word(start + 16'(i) * spread + 16'($urandom_range(0, 60)), 1'b1,
                     (i == npins - 1), t);
        if (npins == 0) add_word(16'($urandom), 1'b0, 1'b1, t);
    endfunction

    logic [31:0] clk_t;
    logic [15:0] rot;
    int nmark;

    initial begin
        trk_en = 0; trk_min_dt = MinIntervalReset; trk_limit = MatchLimitReset;
        clear_tracker();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Disabled: this word causes no result.
        add_word(16'h1234, 1'b1, 1'b1, 32'd5000);
        wait_drained();
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_MIN_INTERVAL, 32'd0);
        write_reg(REG_MATCH_LIMIT, 32'h7FFF);
        // Directed: zero time, half turn, ties, empty markers, surplus pins, time backward.
        add_word(16'h0000, 1'b1, 1'b1, 32'd0);
        add_word(16'h0000, 1'b1, 1'b0, 32'd0);
        add_word(16'hFFFF, 1'b1, 1'b1, 32'd100);
        add_word(16'h8000, 1'b1, 1'b0, 32'd0);
        add_word(16'h0000, 1'b0, 1'b0, 32'd0);
        add_word(16'h7FFF, 1'b1, 1'b1, 32'd101);
        add_word(16'h4000, 1'b1, 1'b1, 32'd50);
        add_word(16'h4000, 1'b1, 1'b1, 32'hFFFFFFFF);
        for (int i = 0; i < 18; i++) add_word(16'(i * 3000), 1'b1, 1'b0, 32'd0);
        add_word(16'h0000, 1'b0, 1'b1, 32'hFFFFFFFF);
        add_word(16'h0100, 1'b1, 1'b1, 32'h10);
        add_word(16'h0140, 1'b1, 1'b1, 32'h11);
        wait_drained();
        hold_feed = 0;
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(REG_ENABLE, (phase == 3) ? 32'd0 : 32'd1);
            if (phase == 3) write_reg(REG_ENABLE, 32'd1);
            case (phase)
                0: write_reg(REG_MIN_INTERVAL, 32'd1000);
                1: write_reg(REG_MIN_INTERVAL, 32'hFFFFFFFF);
                default: write_reg(REG_MIN_INTERVAL, $urandom_range(0, 50));
            endcase
            case (phase)
                0: write_reg(REG_MATCH_LIMIT, 32'd0);
                1, 4: write_reg(REG_MATCH_LIMIT, 32'h7FFF);
                default: write_reg(REG_MATCH_LIMIT, $urandom_range(1, 32767));
            endcase
            clk_t = $urandom_range(1, 1000);
            rot = 16'($urandom);
            for (int f = 0; f < 45; f++) begin
                if ($urandom_range(0, 9) == 0)
                    add_word(16'($urandom), 1'($urandom), 1'($urandom), $urandom);
                else begin
                    nmark = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 20)
                                                         : $urandom_range(0, 6);
                    if ($urandom_range(0, 3) == 0) rot = rot - 16'($urandom_range(0, 3000));
                    else rot = rot + 16'($urandom_range(0, 3000));
                    clk_t = clk_t + (($urandom_range(0, 15) == 0) ? $urandom
                                                               : $urandom_range(0, 2000));
                    add_frame(nmark, rot, 16'($urandom_range(0, 15000)), clk_t);
                end
            end
            if (phase == 2) begin
                hold_feed = 1;
                while (expected_rates.size() != 0 || s_axis_tvalid) @(posedge aclk);
                hold_feed = 0;
            end
            wait_drained();
        end
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/are_pkg.sv
rtl/angular_rate_estimator.sv
dv/tb_angular_rate_estimator.sv
